// ===== hw/rtl/e2m_pkg.sv =====
`default_nettype none

package e2m_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 128;
    localparam int PAGE_SHIFT  = 12;

    // Entry counter holds 0..MAX_ENTRIES
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Field widths fixed by the interface
    localparam int TYPE_W  = 32;
    localparam int ADDR_W  = 64;
    localparam int PAGES_W = 52;
    localparam int ETYPE_W = 3;
    localparam int IDX_W   = 7;
    localparam int COUNT_W = 8;

    // UEFI memory type codes
    localparam logic [TYPE_W-1:0] EFI_RESERVED      = 32'd0;
    localparam logic [TYPE_W-1:0] EFI_LOADER_CODE   = 32'd1;
    localparam logic [TYPE_W-1:0] EFI_LOADER_DATA   = 32'd2;
    localparam logic [TYPE_W-1:0] EFI_BOOT_CODE     = 32'd3;
    localparam logic [TYPE_W-1:0] EFI_BOOT_DATA     = 32'd4;
    localparam logic [TYPE_W-1:0] EFI_RT_CODE       = 32'd5;
    localparam logic [TYPE_W-1:0] EFI_RT_DATA       = 32'd6;
    localparam logic [TYPE_W-1:0] EFI_CONVENTIONAL  = 32'd7;
    localparam logic [TYPE_W-1:0] EFI_UNUSABLE      = 32'd8;
    localparam logic [TYPE_W-1:0] EFI_ACPI_RECLAIM  = 32'd9;
    localparam logic [TYPE_W-1:0] EFI_ACPI_NVS      = 32'd10;
    localparam logic [TYPE_W-1:0] EFI_MMIO          = 32'd11;
    localparam logic [TYPE_W-1:0] EFI_MMIO_PORT     = 32'd12;
    localparam logic [TYPE_W-1:0] EFI_PAL_CODE      = 32'd13;

    // Table entry type codes; NONE marks a skipped descriptor
    localparam logic [ETYPE_W-1:0] ETYPE_NONE     = 3'd0;
    localparam logic [ETYPE_W-1:0] ETYPE_RAM      = 3'd1;
    localparam logic [ETYPE_W-1:0] ETYPE_RESERVED = 3'd2;
    localparam logic [ETYPE_W-1:0] ETYPE_ACPI     = 3'd3;
    localparam logic [ETYPE_W-1:0] ETYPE_NVS      = 3'd4;
    localparam logic [ETYPE_W-1:0] ETYPE_UNUSABLE = 3'd5;

    // Input beat
    typedef struct packed {
        logic [TYPE_W-1:0]  mem_type;
        logic [ADDR_W-1:0]  phys_start;
        logic [PAGES_W-1:0] page_count;
        logic               last_in_map;
    } desc_t;

    // Result beat
    typedef struct packed {
        logic                write_valid;
        logic                merged;
        logic [IDX_W-1:0]    entry_index;
        logic [ADDR_W-1:0]   entry_addr;
        logic [ADDR_W-1:0]   entry_size;
        logic [ETYPE_W-1:0]  entry_type;
        logic [COUNT_W-1:0]  entry_count;
        logic                overflow;
        logic                map_done;
    } result_t;

    // UEFI to table entry type translation
    function automatic logic [ETYPE_W-1:0] map_type(input logic [TYPE_W-1:0] t);
        logic [ETYPE_W-1:0] r;
        case (t)
            EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BOOT_CODE, EFI_BOOT_DATA,
            EFI_CONVENTIONAL: r = ETYPE_RAM;
            EFI_RESERVED, EFI_RT_CODE, EFI_RT_DATA, EFI_MMIO, EFI_MMIO_PORT,
            EFI_PAL_CODE: r = ETYPE_RESERVED;
            EFI_ACPI_RECLAIM: r = ETYPE_ACPI;
            EFI_ACPI_NVS: r = ETYPE_NVS;
            EFI_UNUSABLE: r = ETYPE_UNUSABLE;
            default: r = ETYPE_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/e2m_merge_unit.sv =====
`default_nettype none

// Holds the open E820 entry and the entry count; forms one result per beat.
module e2m_merge_unit
    import e2m_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step,
    input  wire desc_t   desc,
    output result_t      result
);

    logic [ADDR_W-1:0]  open_addr_reg,  open_addr_next;
    logic [ADDR_W-1:0]  open_size_reg,  open_size_next;
    logic [ETYPE_W-1:0] open_type_reg,  open_type_next;
    logic [CNT_W-1:0]   used_reg,       used_next;

    logic [ETYPE_W-1:0] etype;
    logic [ADDR_W-1:0]  bytes;
    logic [ADDR_W-1:0]  open_end;
    logic [ADDR_W-1:0]  grown_size;
    logic               can_merge;
    logic               has_room;
    logic [CNT_W-1:0]   used_dec;

    // Decode and compare against the open entry
    always_comb begin
        etype      = map_type(desc.mem_type);
        bytes      = ADDR_W'(desc.page_count) << PAGE_SHIFT;
        open_end   = open_addr_reg + open_size_reg;
        grown_size = open_size_reg + bytes;
        can_merge  = (used_reg != '0) && (open_type_reg == etype) &&
                     (open_end == desc.phys_start);
        has_room   = (used_reg < CNT_W'(MAX_ENTRIES));
        used_dec   = used_reg - CNT_W'(1);
    end

    // Result and next state
    always_comb begin
        open_addr_next = open_addr_reg;
        open_size_next = open_size_reg;
        open_type_next = open_type_reg;
        used_next      = used_reg;

        result             = '0;
        result.map_done    = desc.last_in_map;

        if (etype != ETYPE_NONE) begin
            if (can_merge) begin
                open_size_next     = grown_size;
                result.write_valid = 1'b1;
                result.merged      = 1'b1;
                result.entry_index = used_dec[IDX_W-1:0];
                result.entry_addr  = open_addr_reg;
                result.entry_size  = grown_size;
                result.entry_type  = etype;
            end else if (has_room) begin
                open_addr_next     = desc.phys_start;
                open_size_next     = bytes;
                open_type_next     = etype;
                used_next          = used_reg + CNT_W'(1);
                result.write_valid = 1'b1;
                result.entry_index = used_reg[IDX_W-1:0];
                result.entry_addr  = desc.phys_start;
                result.entry_size  = bytes;
                result.entry_type  = etype;
            end else begin
                result.overflow    = 1'b1;
            end
        end

        // count is reported before the end-of-map clear
        result.entry_count = COUNT_W'(used_next);

        if (desc.last_in_map) begin
            open_addr_next = '0;
            open_size_next = '0;
            open_type_next = ETYPE_NONE;
            used_next      = '0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_addr_reg <= '0;
            open_size_reg <= '0;
            open_type_reg <= ETYPE_NONE;
            used_reg      <= '0;
        end else if (step) begin
            open_addr_reg <= open_addr_next;
            open_size_reg <= open_size_next;
            open_type_reg <= open_type_next;
            used_reg      <= used_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/efi_to_e820_map_merge.sv =====
`default_nettype none

// Channel   Ports                          Direction  Beat
// -------   -----------------------------  ---------  ---------------------------
// s_        s_valid, s_ready, s_desc       in         one UEFI memory descriptor
// m_        m_valid, m_ready, m_result     out        one E820 table write record
//
// One beat per cycle unless m_ready stalls; m_valid rises when the beat reaches the result register.
// The path from input register to result register is one 64-bit add and
// compare (end of the open entry) plus the 64-bit size add.
// aresetn (synchronous) empties both registers and clears the open entry.
// A stalled m_ready holds the result; s_ready stays high while the input
// register is empty or moving on.
module efi_to_e820_map_merge
    import e2m_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire desc_t   s_desc,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    in_valid_reg;
    desc_t   in_desc_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t calc_result;
    logic    out_free;
    logic    step;

    // Handshake control
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_desc_reg <= s_desc;
        end
    end

    e2m_merge_unit u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .desc    (in_desc_reg),
        .result  (calc_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_result_reg <= calc_result;
        end
    end

    // Checks
    a_ovf_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.overflow |-> !m_result.write_valid)
        else $error("overflow beat also carries a table write");

    a_merge_is_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.merged |-> m_result.write_valid)
        else $error("merged flag without a table write");

    a_index_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.write_valid |->
            m_result.entry_count[IDX_W-1:0] == IDX_W'(m_result.entry_index + 1'b1))
        else $error("entry count does not follow written slot");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.write_valid |->
            m_result.entry_addr == '0 && m_result.entry_size == '0)
        else $error("skipped beat carries entry data");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
